// ----- hw/rtl/resk_pkg.sv -----
package resk_pkg;

	localparam int KEY_W = 8;
	localparam int TAG_W = 16;

	// one stored record: key and the tag that travels with it
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// one sorted result handed from the sorter to the output register
	typedef struct packed {
		rec_t rec;
		logic last;
		logic ovf;
	} emit_t;

endpackage

// ----- hw/rtl/resk_sorter.sv -----
module resk_sorter #(
	parameter int MAX_RECORDS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [resk_pkg::KEY_W-1:0]  sort_key,
	input  logic [resk_pkg::TAG_W-1:0]  record_tag,
	input  logic                        last_in,
	output logic                        emit_valid,
	input  logic                        emit_ready,
	output resk_pkg::emit_t             emit
);
	import resk_pkg::*;

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECORDS);

	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_FETCH = 5'b00010,
		S_HEAD  = 5'b00100,
		S_SCAN  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic            ovf_q;
	logic [CW-1:0]   a_q;
	logic [CW-1:0]   b_q;
	rec_t            cur_q;

	rec_t            mem [MAX_RECORDS];
	rec_t            rd_data;
	logic [AW-1:0]   rd_addr;
	logic            we;
	logic [AW-1:0]   waddr;
	rec_t            wdata;

	logic            in_fire;
	logic            emit_fire;
	logic            room;
	logic            swap;
	logic            final_rec;
	logic [CW-1:0]   a_nxt;
	logic [CW-1:0]   b_nxt;

	// handshake and compare
	assign in_ready   = (state_q == S_LOAD);
	assign in_fire    = in_valid & in_ready;
	assign emit_valid = (state_q == S_EMIT);
	assign emit_fire  = emit_valid & emit_ready;
	assign room       = (cnt_q < CNT_MAX);
	assign a_nxt      = a_q + CW'(1);
	assign b_nxt      = b_q + CW'(1);
	assign swap       = (rd_data.key < cur_q.key);
	assign final_rec  = (a_nxt == cnt_q);

	// held record is final for position a once its scan is done
	assign emit.rec  = cur_q;
	assign emit.last = final_rec;
	assign emit.ovf  = ovf_q;

	// memory write port: loads in load phase, displaced record in scan phase
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = '{key: sort_key, tag: record_tag};
		case (state_q)
			S_LOAD: begin
				we = in_fire & room;
			end
			S_SCAN: begin
				we    = swap;
				waddr = b_q[AW-1:0];
				wdata = cur_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// memory read address, issued in the cycle before its data is used
	always_comb begin
		case (state_q)
			S_FETCH: rd_addr = a_q[AW-1:0];
			S_HEAD:  rd_addr = a_nxt[AW-1:0];
			S_SCAN:  rd_addr = b_nxt[AW-1:0];
			S_EMIT:  rd_addr = a_nxt[AW-1:0];
			default: rd_addr = a_q[AW-1:0];
		endcase
	end

	// record memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data <= mem[rd_addr];
	end

	// sequencer: load, then per position fetch, scan later entries, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end
						ovf_q <= ovf_q | ~room;
						if (last_in) begin
							a_q     <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					b_q <= a_nxt;
					if (a_nxt < cnt_q) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					b_q <= b_nxt;
					if (b_nxt == cnt_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						if (final_rec) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							a_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							a_q     <= a_nxt;
							state_q <= S_HEAD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// held record: head of the scan, swapped with any smaller key
	always_ff @(posedge clk) begin
		if (state_q == S_HEAD) begin
			cur_q <= rd_data;
		end else if (state_q == S_SCAN && swap) begin
			cur_q <= rd_data;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("record count beyond capacity");

	a_pos_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (a_q < cnt_q))
		else $error("sort position outside the stored set");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (b_q > a_q && b_q < cnt_q))
		else $error("scan index outside the later positions");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && we) |-> (waddr != rd_addr))
		else $error("write and read of the same entry in one cycle");

	a_run_close: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && final_rec) |=> (state_q == S_LOAD && cnt_q == '0 && !ovf_q))
		else $error("set not closed after its final result");
`endif

endmodule

// ----- hw/rtl/record_exchange_sort_by_key_core.sv -----
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------
// in      | into core | in_valid / in_ready   | sort_key, record_tag, last_in
// out     | from core | out_valid / out_ready | sorted_key, sorted_tag, last_out, overflowed
//
// in_ready is low from the last record of a set until its final result has gone into the
// output register.
// a sort then does one compare per cycle, bounded by the single read port of the record
// memory, plus a head and an emit step per sorted position and a fetch step to start.
// arst_n clears the sequencer, the record count, the overflow flag and the output valid.
// a stall on out holds the sequencer in its emit step; the output register frees the
// sorter while one result waits.
module record_exchange_sort_by_key_core #(
	parameter int MAX_RECORDS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [resk_pkg::KEY_W-1:0]  sort_key,
	input  logic [resk_pkg::TAG_W-1:0]  record_tag,
	input  logic                        last_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [resk_pkg::KEY_W-1:0]  sorted_key,
	output logic [resk_pkg::TAG_W-1:0]  sorted_tag,
	output logic                        last_out,
	output logic                        overflowed
);
	import resk_pkg::*;

	logic   emit_valid;
	logic   emit_ready;
	emit_t  emit;
	logic   out_valid_q;
	emit_t  out_q;

	resk_sorter #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_sorter (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sort_key   (sort_key),
		.record_tag (record_tag),
		.last_in    (last_in),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit       (emit)
	);

	// output register takes a new transaction when empty or being drained
	assign emit_ready = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid && emit_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && emit_ready) begin
			out_q <= emit;
		end
	end

	// result ports
	assign out_valid  = out_valid_q;
	assign sorted_key = out_q.rec.key;
	assign sorted_tag = out_q.rec.tag;
	assign last_out   = out_q.last;
	assign overflowed = out_q.ovf;

endmodule
